[hdl/tlb_page_table_translator_defines.svh]
// Assertion macros shared by the translator RTL files.
// Depends on nothing; included by name where assertions are written.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLBPT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlbpt assertion failed");

// Next-cycle implication, disabled during reset.
`define TLBPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlbpt assertion failed");

`endif

[hdl/tlbpt_pkg.sv]
// Shared types, codes and default sizes of the TLB / page-table translator.
// Depends on nothing; used by scoped names in the top level, controller and datapath.
`default_nettype none

package tlbpt_pkg;

   localparam int ADDR_W            = 32;
   localparam int FRAME_W           = 20;
   localparam int PAGE_W            = 20;
   localparam int TLB_ENTRIES_DEF   = 4;
   localparam int PAGE_SHIFT_DEF    = 12;
   localparam int TABLE_ENTRIES_DEF = 256;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_TRANSLATE = 2'd0;
   localparam mode_type MODE_MAP       = 2'd1;
   localparam mode_type MODE_FLUSH     = 2'd2;

   typedef logic [1:0] source_type;
   localparam source_type SRC_TLB   = 2'd0;
   localparam source_type SRC_TABLE = 2'd1;
   localparam source_type SRC_FAULT = 2'd2;
   localparam source_type SRC_NONE  = 2'd3;

   // Controller to datapath.
   typedef struct packed {
      logic clear;   // sweep one page-table row
      logic accept;  // capture a request beat and access the table
      logic exec;    // resolve the captured request
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_last;  // sweep is at its final row
   } status_type;

endpackage

`default_nettype wire

[hdl/tlb_page_table_translator.sv]
// Top level of the TLB / single-level page-table address translator.
// Depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_datapath and tlbpt_ram.
//
// A request beat is taken at a rising edge with start high and busy low. The
// accepting cycle issues the page-table RAM access for an in-range page (read
// for translate, write for map); the next cycle resolves the TLB compare
// against the registered RAM data, updates TLB, victim pointer and counters,
// and registers the result. rsp_valid pulses for exactly one cycle in the
// cycle after that, alongside the result and counter values; the receiver
// cannot stall it, so sample it when it pulses. busy drops again while the
// result is shown. busy is high while a beat is resolved, so a new beat is
// taken only once the last one is through the accept/resolve sequence, which
// shares the single RAM port. After reset the page table is swept clear, one
// row a cycle, and busy stays high until every row has been cleared.
`default_nettype none

module tlb_page_table_translator #(
   parameter int TLB_ENTRIES   = tlbpt_pkg::TLB_ENTRIES_DEF,
   parameter int PAGE_SHIFT    = tlbpt_pkg::PAGE_SHIFT_DEF,
   parameter int TABLE_ENTRIES = tlbpt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [tlbpt_pkg::ADDR_W-1:0]  req_virtual_addr,
   input  wire logic [tlbpt_pkg::PAGE_W-1:0]  req_map_page,
   input  wire logic [tlbpt_pkg::FRAME_W-1:0] req_map_frame,
   output logic                               rsp_valid,
   output logic                               rsp_success,
   output logic [tlbpt_pkg::ADDR_W-1:0]       rsp_phys_addr,
   output logic [1:0]                         rsp_source,
   output logic [tlbpt_pkg::ADDR_W-1:0]       rsp_hit_count,
   output logic [tlbpt_pkg::ADDR_W-1:0]       rsp_miss_count,
   output logic [tlbpt_pkg::ADDR_W-1:0]       rsp_fault_count
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   tlbpt_pkg::cmd_type    cmd;
   tlbpt_pkg::status_type status;

   // page-table RAM port; each row holds {valid, frame}
   logic                          ram_en;
   logic                          ram_we;
   logic [IDX_W-1:0]              ram_addr;
   logic [tlbpt_pkg::FRAME_W:0]   ram_wdata;
   logic [tlbpt_pkg::FRAME_W:0]   ram_rdata;

   // sequence: sweep, then accept / resolve per beat
   tlbpt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // hold the request, run the TLB and counters, drive the result
   tlbpt_datapath #(
      .TLB_ENTRIES   (TLB_ENTRIES),
      .PAGE_SHIFT    (PAGE_SHIFT),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_virtual_addr  (req_virtual_addr),
      .req_map_page      (req_map_page),
      .req_map_frame     (req_map_frame),
      .ram_en            (ram_en),
      .ram_we            (ram_we),
      .ram_addr          (ram_addr),
      .ram_wdata         (ram_wdata),
      .ram_rdata         (ram_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_success       (rsp_success),
      .rsp_phys_addr     (rsp_phys_addr),
      .rsp_source        (rsp_source),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_miss_count    (rsp_miss_count),
      .rsp_fault_count   (rsp_fault_count)
   );

   // page table storage
   tlbpt_ram #(
      .WIDTH (tlbpt_pkg::FRAME_W + 1),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

[hdl/tlbpt_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module tlbpt_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hdl/tlbpt_ctrl.sv]
// Controller: clearing sweep after reset, then accept / execute sequencing.
// Depends on tlbpt_pkg and the assertion macro header.
`default_nettype none
`include "tlb_page_table_translator_defines.svh"

module tlbpt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire tlbpt_pkg::status_type status,
   output tlbpt_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.clear  = (state_ff == ST_CLEAR);
   assign cmd.accept = (state_ff == ST_IDLE) && start;
   assign cmd.exec   = (state_ff == ST_EXEC);

   `TLBPT_ASSERT_NEXT(a_clear_holds, clock, reset,
                      (state_ff == ST_CLEAR) && !status.clear_last, state_ff == ST_CLEAR)
   `TLBPT_ASSERT_NEXT(a_accept_execs, clock, reset, cmd.accept, cmd.exec && busy)

endmodule

`default_nettype wire

[hdl/tlbpt_datapath.sv]
// Datapath: request capture, TLB registers, page-table access, counters, result.
// Depends on tlbpt_pkg and the assertion macro header; drives the page-table RAM.
`default_nettype none
`include "tlb_page_table_translator_defines.svh"

module tlbpt_datapath #(
   parameter int TLB_ENTRIES   = tlbpt_pkg::TLB_ENTRIES_DEF,
   parameter int PAGE_SHIFT    = tlbpt_pkg::PAGE_SHIFT_DEF,
   parameter int TABLE_ENTRIES = tlbpt_pkg::TABLE_ENTRIES_DEF,
   localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tlbpt_pkg::cmd_type            cmd,
   output tlbpt_pkg::status_type              status,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [tlbpt_pkg::ADDR_W-1:0]  req_virtual_addr,
   input  wire logic [tlbpt_pkg::PAGE_W-1:0]  req_map_page,
   input  wire logic [tlbpt_pkg::FRAME_W-1:0] req_map_frame,
   output logic                               ram_en,
   output logic                               ram_we,
   output logic [IDX_W-1:0]                   ram_addr,
   output logic [tlbpt_pkg::FRAME_W:0]        ram_wdata,
   input  wire logic [tlbpt_pkg::FRAME_W:0]   ram_rdata,
   output logic                               rsp_valid,
   output logic                               rsp_success,
   output logic [tlbpt_pkg::ADDR_W-1:0]       rsp_phys_addr,
   output logic [1:0]                         rsp_source,
   output logic [tlbpt_pkg::ADDR_W-1:0]       rsp_hit_count,
   output logic [tlbpt_pkg::ADDR_W-1:0]       rsp_miss_count,
   output logic [tlbpt_pkg::ADDR_W-1:0]       rsp_fault_count
);

   localparam int VPN_W = tlbpt_pkg::ADDR_W - PAGE_SHIFT;
   localparam int VIC_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int FW    = tlbpt_pkg::FRAME_W;
   localparam int AW    = tlbpt_pkg::ADDR_W;

   // clearing sweep
   logic [IDX_W-1:0] clr_idx_ff;

   // captured request
   tlbpt_pkg::mode_type         mode_ff;
   logic [VPN_W-1:0]            vpn_ff;
   logic [PAGE_SHIFT-1:0]       offset_ff;
   logic                        in_range_ff;

   // TLB
   logic [VPN_W-1:0] tlb_page_ff  [TLB_ENTRIES];
   logic [FW-1:0]    tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid_ff, tlb_valid_in;
   logic [VIC_W-1:0] victim_ff, victim_in;
   logic             fill;

   // counters
   logic [AW-1:0] hits_ff, hits_in, misses_ff, misses_in, faults_ff, faults_in;

   // result
   logic                     rsp_valid_ff;
   logic                     success_ff, success_in;
   logic [AW-1:0]            phys_ff, phys_in;
   tlbpt_pkg::source_type    source_ff, source_in;

   logic [VPN_W-1:0] req_vpn;
   logic             vpn_in_range, map_in_range;
   logic             hit;
   logic [VIC_W-1:0] hit_idx;
   logic             table_valid;
   logic [FW-1:0]    table_frame;

   assign req_vpn      = req_virtual_addr[AW-1:PAGE_SHIFT];
   assign vpn_in_range = (AW'(req_vpn) < AW'(TABLE_ENTRIES));
   assign map_in_range = (AW'(req_map_page) < AW'(TABLE_ENTRIES));

   assign status.clear_last = (clr_idx_ff == IDX_W'(TABLE_ENTRIES - 1));

   // page-table port: sweep, map write or translate read
   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = req_vpn[IDX_W-1:0];
      ram_wdata = {1'b1, req_map_frame};
      if (cmd.clear) begin
         ram_en    = 1'b1;
         ram_we    = 1'b1;
         ram_addr  = clr_idx_ff;
         ram_wdata = '0;
      end else if (cmd.accept) begin
         if (req_mode == tlbpt_pkg::MODE_MAP) begin
            ram_en   = map_in_range;
            ram_we   = map_in_range;
            ram_addr = req_map_page[IDX_W-1:0];
         end else if (req_mode == tlbpt_pkg::MODE_TRANSLATE) begin
            ram_en = vpn_in_range;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clear) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff     <= req_mode;
         vpn_ff      <= req_vpn;
         offset_ff   <= req_virtual_addr[PAGE_SHIFT-1:0];
         in_range_ff <= (req_mode == tlbpt_pkg::MODE_MAP) ? map_in_range : vpn_in_range;
      end
   end

   // lowest valid matching slot answers
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
         if (tlb_valid_ff[i] && (tlb_page_ff[i] == vpn_ff)) begin
            hit     = 1'b1;
            hit_idx = VIC_W'(i);
         end
      end
   end

   // read data is stale unless the row was read for this request
   assign table_valid = ram_rdata[FW] && in_range_ff;
   assign table_frame = ram_rdata[FW-1:0];

   always_comb begin
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      faults_in    = faults_ff;
      tlb_valid_in = tlb_valid_ff;
      victim_in    = victim_ff;
      fill         = 1'b0;
      success_in   = 1'b0;
      phys_in      = '0;
      source_in    = tlbpt_pkg::SRC_NONE;
      if (cmd.exec) begin
         unique case (mode_ff)
            tlbpt_pkg::MODE_TRANSLATE: begin
               if (hit) begin
                  hits_in    = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
                  success_in = 1'b1;
                  phys_in    = AW'({tlb_frame_ff[hit_idx], {PAGE_SHIFT{1'b0}}})
                               | AW'(offset_ff);
                  source_in  = tlbpt_pkg::SRC_TLB;
               end else begin
                  misses_in = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
                  if (table_valid) begin
                     fill                    = 1'b1;
                     tlb_valid_in[victim_ff] = 1'b1;
                     victim_in  = (victim_ff == VIC_W'(TLB_ENTRIES - 1)) ? '0
                                                                         : victim_ff + 1'b1;
                     success_in = 1'b1;
                     phys_in    = AW'({table_frame, {PAGE_SHIFT{1'b0}}})
                                  | AW'(offset_ff);
                     source_in  = tlbpt_pkg::SRC_TABLE;
                  end else begin
                     faults_in = (faults_ff == '1) ? faults_ff : faults_ff + 1'b1;
                     source_in = tlbpt_pkg::SRC_FAULT;
                  end
               end
            end
            tlbpt_pkg::MODE_MAP: begin
               success_in = in_range_ff;
            end
            tlbpt_pkg::MODE_FLUSH: begin
               tlb_valid_in = '0;
               success_in   = 1'b1;
            end
            default: begin
               success_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         misses_ff    <= '0;
         faults_ff    <= '0;
         tlb_valid_ff <= '0;
         victim_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         faults_ff    <= faults_in;
         tlb_valid_ff <= tlb_valid_in;
         victim_ff    <= victim_in;
         rsp_valid_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (fill) begin
         tlb_page_ff[victim_ff]  <= vpn_ff;
         tlb_frame_ff[victim_ff] <= table_frame;
      end
      if (cmd.exec) begin
         success_ff <= success_in;
         phys_ff    <= phys_in;
         source_ff  <= source_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = success_ff;
   assign rsp_phys_addr   = phys_ff;
   assign rsp_source      = source_ff;
   assign rsp_hit_count   = hits_ff;
   assign rsp_miss_count  = misses_ff;
   assign rsp_fault_count = faults_ff;

   `TLBPT_ASSERT_SAME(a_rsp_after_exec, clock, reset, rsp_valid_ff, $past(cmd.exec))
   `TLBPT_ASSERT_NEXT(a_hits_monotonic, clock, reset, 1'b1, hits_ff >= $past(hits_ff))
   `TLBPT_ASSERT_NEXT(a_counts_only_on_exec, clock, reset, !cmd.exec,
                      $stable(hits_ff) && $stable(misses_ff) && $stable(faults_ff))

endmodule

`default_nettype wire
